// ===== sv/lphm_pkg.sv =====
// Shared types and constants of the linear-probing hash map.
package lphm_pkg;

  // Multiplier of the home-slot hash
  localparam logic [31:0] HASH_MULT = 32'd1048583;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_GET = 2'd0,
    MODE_SET = 2'd1,
    MODE_DEL = 2'd2
  } mode_t;

  // Result codes carried in the status field
  typedef enum logic [1:0] {
    STAT_HIT      = 2'd0,
    STAT_MISS     = 2'd1,
    STAT_INSERTED = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_P_RD,
    S_P_CMP,
    S_W_RD,
    S_W_CMP,
    S_M_RD,
    S_M_CMP,
    S_M_CLR,
    S_FIN
  } state_t;

endpackage

// ===== sv/lphm_if.sv =====
// Request and response channel interfaces of the hash map.
interface lphm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key;
  logic [31:0] value_in;

  modport source (output valid, output mode, output key, output value_in, input ready);
  modport sink   (input valid, input mode, input key, input value_in, output ready);
endinterface

interface lphm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [10:0] entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

// ===== sv/linear_probe_hash_map_core.sv =====
// Linear-probing hash map: slot memory, probe sequencer and result register.
//
//  channel   dir  word                             handshake
//  in_req    in   mode, key, value_in              valid/ready
//  out_rsp   out  status, value_out, entry_count   valid/ready
//
// A probe step is a memory read, then a compare. A delete then walks the run
// after the hole: each entry of the run is re-probed from its home slot and
// moves, its old slot freed, when an unused slot comes first; the walk ends
// at an unused slot or back at the hole. After reset the block sweeps every
// slot to unused and takes no request until the sweep ends. Requests are
// taken in the idle state even while a response waits; a finished result
// then holds until out_rsp drains. TABLE_DEPTH must be a power of two.
module linear_probe_hash_map_core
  import lphm_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  lphm_req_if.sink   in_req,
  lphm_rsp_if.source out_rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int ENT_W = 1 + KEY_W + VAL_W;
  localparam logic [IDX_W-1:0] MULT_LO = IDX_W'(HASH_MULT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Control registers
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working and payload registers
  logic [1:0]        mode_r, mode_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [IDX_W-1:0]  hole_r, hole_nxt;
  logic [IDX_W-1:0]  walk_r, walk_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic [10:0]       out_count_r, out_count_nxt;

  // Slot memory: {used, key, value} per slot
  logic [ENT_W-1:0]  mem [TABLE_DEPTH];
  logic [ENT_W-1:0]  rd_q_r;
  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [ENT_W-1:0]  wr_data;

  logic              q_used;
  logic [KEY_W-1:0]  q_key;
  logic [VAL_W-1:0]  q_val;
  logic [KEY_W-1:0]  in_key, hash_key;
  logic [VAL_W-1:0]  in_val;
  logic [IDX_W-1:0]  hash_idx, idx_inc;
  logic              key_eq;

  assign q_used = rd_q_r[ENT_W-1];
  assign q_key  = rd_q_r[VAL_W +: KEY_W];
  assign q_val  = rd_q_r[VAL_W-1:0];
  assign in_key = in_req.key[KEY_W-1:0];
  assign in_val = in_req.value_in[VAL_W-1:0];

  // Shared hash unit: request key when idle, else the entry being re-probed
  assign hash_key = (state_r == S_IDLE) ? in_key : q_key;
  assign hash_idx = IDX_W'(IDX_W'(hash_key) * MULT_LO);

  // Shared compare and step
  assign key_eq  = (q_key == key_r);
  assign idx_inc = idx_r + IDX_W'(1);

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Sequencer: next state, memory strobes and result
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    hole_nxt       = hole_r;
    walk_nxt       = walk_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = {1'b1, key_r, val_r};

    case (state_r)
      // Sweep every slot to unused after reset
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request and hash its key
      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt       = in_req.mode;
          key_nxt        = in_key;
          val_nxt        = in_val;
          idx_nxt        = hash_idx;
          start_nxt      = hash_idx;
          res_value_nxt  = '0;
          res_status_nxt = STAT_MISS;
          if (in_req.mode == MODE_GET || in_req.mode == MODE_SET ||
              in_req.mode == MODE_DEL) begin
            state_nxt = S_P_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_P_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_P_CMP;
      end

      // Main probe: stop on the key, an unused slot or a wrap round the table
      S_P_CMP: begin
        if (!q_used || key_eq) begin
          state_nxt = S_FIN;
          case (mode_r)
            MODE_GET: begin
              if (q_used) begin
                res_status_nxt = STAT_HIT;
                res_value_nxt  = q_val;
              end
            end
            MODE_SET: begin
              wr_en = 1'b1;
              if (q_used) begin
                res_status_nxt = STAT_HIT;
              end else begin
                res_status_nxt = STAT_INSERTED;
                count_nxt      = count_r + CNT_W'(1);
              end
            end
            MODE_DEL: begin
              if (q_used) begin
                wr_en          = 1'b1;
                wr_data        = {1'b0, key_r, val_r};
                res_status_nxt = STAT_HIT;
                if (count_r != '0) begin
                  count_nxt = count_r - CNT_W'(1);
                end
                hole_nxt  = idx_r;
                walk_nxt  = idx_inc;
                state_nxt = S_W_RD;
              end
            end
            default: begin
              res_status_nxt = STAT_MISS;
            end
          endcase
        end else if (idx_inc == start_r) begin
          // wrapped round a full table
          res_status_nxt = (mode_r == MODE_SET) ? STAT_FULL : STAT_MISS;
          state_nxt      = S_FIN;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_P_RD;
        end
      end

      // Walk the run after the hole
      S_W_RD: begin
        if (walk_r == hole_r) begin
          state_nxt = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = walk_r;
          state_nxt = S_W_CMP;
        end
      end

      S_W_CMP: begin
        if (!q_used) begin
          state_nxt = S_FIN;
        end else begin
          key_nxt   = q_key;
          val_nxt   = q_val;
          idx_nxt   = hash_idx;
          start_nxt = hash_idx;
          state_nxt = S_M_RD;
        end
      end

      S_M_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r;
        state_nxt = S_M_CMP;
      end

      // Re-probe of a run entry; move it if an unused slot comes first
      S_M_CMP: begin
        if (!q_used) begin
          if (idx_r != walk_r) begin
            wr_en     = 1'b1;
            state_nxt = S_M_CLR;
          end else begin
            walk_nxt  = walk_r + IDX_W'(1);
            state_nxt = S_W_RD;
          end
        end else if (key_eq || idx_inc == start_r) begin
          walk_nxt  = walk_r + IDX_W'(1);
          state_nxt = S_W_RD;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_M_RD;
        end
      end

      // Free the slot the entry moved out of
      S_M_CLR: begin
        wr_en     = 1'b1;
        wr_addr   = walk_r;
        wr_data   = {1'b0, key_r, val_r};
        walk_nxt  = walk_r + IDX_W'(1);
        state_nxt = S_W_RD;
      end

      // Hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = 32'(res_value_r);
          out_count_nxt  = 11'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    hole_r       <= hole_nxt;
    walk_r       <= walk_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.value_out   = out_value_r;
  assign out_rsp.entry_count = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1)) || (count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("response raised outside the finish state");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_FIN) |-> !wr_en)
    else $error("slot memory written while no operation runs");

endmodule
